[rtl/first_fit_free_list_allocator_defines.svh]
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, clocked on clk_i, quiet while rst_ni is low
`define FFFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, quiet while rst_ni is low
`define FFFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fffl_pkg.sv]
// shared types and constants of the first-fit free-list allocator
package fffl_pkg;

  // request action codes
  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  // response status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  // register map (word index)
  localparam logic REG_HEAP_LIMIT = 1'b0;
  localparam logic [15:0] HEAP_LIMIT_RESET = 16'h8000;

  // heap granule
  localparam int unsigned ALIGN_BYTES = 8;
  localparam int unsigned ALIGN_SHIFT = 3;
  localparam logic [16:0] ALIGN_MASK  = 17'h00007;

  // width of the shared add-compare unit
  localparam int unsigned UNIT_W = 18;

  // strobes from the sequencer to the block store
  typedef struct packed {
    logic rd_en;
    logic size_we;
    logic next_we;
    logic prior_we;
    logic head_we;
  } store_ctl_t;

endpackage

[rtl/fffl_if.sv]
// request and response channel interfaces of the allocator

interface fffl_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] request_size;
  logic [15:0] block_offset;

  modport source (output valid, output action, output request_size, output block_offset,
                  input ready);
  modport sink   (input valid, input action, input request_size, input block_offset,
                  output ready);
endinterface

interface fffl_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] payload_offset;

  modport source (output valid, output status, output payload_offset, input ready);
  modport sink   (input valid, input status, input payload_offset, output ready);
endinterface

[rtl/fffl_apb.sv]
// apb register slave holding the heap limit
module fffl_apb
  import fffl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] heap_limit_o
);

  logic [15:0] heap_limit_q;
  logic        hit;

  assign hit    = (paddr[2] == REG_HEAP_LIMIT);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HEAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && hit) begin
      heap_limit_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {16'b0, heap_limit_q};
    end
  end

  assign heap_limit_o = heap_limit_q;

endmodule

[rtl/fffl_cmp.sv]
// shared add-compare unit: sum = a + b, ge = ref >= sum
module fffl_cmp
  import fffl_pkg::*;
(
  input  logic [UNIT_W-1:0] add_a_i,
  input  logic [UNIT_W-1:0] add_b_i,
  input  logic [UNIT_W-1:0] ref_i,
  output logic [UNIT_W-1:0] sum_o,
  output logic              ge_o
);

  assign sum_o = add_a_i + add_b_i;
  assign ge_o  = (ref_i >= sum_o);

endmodule

[rtl/fffl_store.sv]
// block store: size and link memories plus the sentinel head pointer
module fffl_store
  import fffl_pkg::*;
#(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  store_ctl_t    ctl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] size_waddr_i,
  input  logic [15:0]   size_wdata_i,
  input  logic [AW-1:0] next_waddr_i,
  input  logic [AW-1:0] next_wdata_i,
  input  logic [AW-1:0] prior_waddr_i,
  input  logic [AW-1:0] prior_wdata_i,
  input  logic [AW-1:0] head_wdata_i,
  output logic [15:0]   rd_size_o,
  output logic [AW-1:0] rd_next_o,
  output logic [AW-1:0] rd_prior_o,
  output logic [AW-1:0] head_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [15:0]   size_mem  [DEPTH];
  logic [AW-1:0] next_mem  [DEPTH];
  logic [AW-1:0] prior_mem [DEPTH];
  logic [AW-1:0] head_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.size_we) begin
      size_mem[size_waddr_i] <= size_wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_size_o <= size_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.next_we) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_next_o <= next_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prior_we) begin
      prior_mem[prior_waddr_i] <= prior_wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_prior_o <= prior_mem[rd_addr_i];
    end
  end

  // sentinel forward link lives in a flop so reset gives an empty list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (ctl_i.head_we) begin
      head_q <= head_wdata_i;
    end else if (ctl_i.next_we && (next_waddr_i == '0)) begin
      head_q <= next_wdata_i;
    end
  end

  assign head_o = head_q;

endmodule

[rtl/first_fit_free_list_allocator.sv]
// top level of the first-fit explicit free-list heap allocator
//
//   port      dir  handshake          carries
//   req_i     in   valid/ready        action, request_size, block_offset
//   rsp_o     out  valid/ready        status, payload_offset
//   apb       in   psel/penable       heap_limit_bytes at word 0
//
// allocate walks k free-list nodes (k up to HEAP_BYTES/8), one node per read of
//   the block store, and goes straight to extension when the list is empty
// free does a head insert, then a back-link write
// reset is asynchronous and active low; the sentinel link sits in flops, so no
//   clearing pass runs and the block accepts requests right after reset
// a finished response waits in the output register; the sequencer holds its
//   last step until that register is free, and req_i.ready is low while busy
module first_fit_free_list_allocator
  import fffl_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 32768,  // power of two
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fffl_req_if.sink    req_i,
  fffl_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "first_fit_free_list_allocator_defines.svh"

  localparam int unsigned DEPTH    = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned AW       = $clog2(DEPTH);
  // extension can never pass what a 16-bit limit allows
  localparam int unsigned HEAP_CAP = (HEAP_BYTES > 65535) ? 65535 : HEAP_BYTES;
  localparam logic [AW:0] DEPTH_W  = (AW+1)'(DEPTH);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_WALK      = 6'b000010,
    S_UNLINK    = 6'b000100,
    S_EXTEND    = 6'b001000,
    S_FREE_HEAD = 6'b010000,
    S_FREE_LINK = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [16:0]   need_q, need_d;
  logic [AW-1:0] node_q, node_d;
  logic [AW:0]   steps_q, steps_d;
  logic [AW-1:0] blk_q, blk_d;
  logic [AW-1:0] p_q, p_d;
  logic [AW-1:0] n_q, n_d;
  logic [AW-1:0] fb_q, fb_d;
  logic [AW-1:0] tgt_q, tgt_d;
  logic [15:0]   heap_top_q, heap_top_d;

  logic          out_valid_q;
  logic          out_status_q;
  logic [15:0]   out_payload_q;

  // block store wiring
  store_ctl_t    ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] size_waddr;
  logic [15:0]   size_wdata;
  logic [AW-1:0] next_waddr, next_wdata;
  logic [AW-1:0] prior_waddr, prior_wdata;
  logic [AW-1:0] head_wdata;
  logic [15:0]   rd_size;
  logic [AW-1:0] rd_next, rd_prior, head;

  // shared unit wiring
  logic [UNIT_W-1:0] unit_a, unit_b, unit_ref, unit_sum;
  logic              unit_ge;

  logic [15:0]   heap_limit;
  logic [15:0]   limit;
  logic [16:0]   need_in;
  logic [15:0]   free_byte;
  logic [31:0]   free_ext;
  logic [AW-1:0] free_idx;
  logic [31:0]   top_ext;
  logic [AW-1:0] top_idx;
  logic [15:0]   blk_payload;
  logic [AW:0]   steps_inc;
  logic          out_free;
  logic          fin;
  logic          fin_status;
  logic [15:0]   fin_payload;

  fffl_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .heap_limit_o (heap_limit)
  );

  fffl_store #(
    .AW (AW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .rd_addr_i     (rd_addr),
    .size_waddr_i  (size_waddr),
    .size_wdata_i  (size_wdata),
    .next_waddr_i  (next_waddr),
    .next_wdata_i  (next_wdata),
    .prior_waddr_i (prior_waddr),
    .prior_wdata_i (prior_wdata),
    .head_wdata_i  (head_wdata),
    .rd_size_o     (rd_size),
    .rd_next_o     (rd_next),
    .rd_prior_o    (rd_prior),
    .head_o        (head)
  );

  fffl_cmp u_cmp (
    .add_a_i (unit_a),
    .add_b_i (unit_b),
    .ref_i   (unit_ref),
    .sum_o   (unit_sum),
    .ge_o    (unit_ge)
  );

  // header plus payload, rounded up to the granule, kept at full width
  assign need_in = (17'(HEADER_BYTES) + {1'b0, req_i.request_size} + 17'(ALIGN_BYTES - 1))
                   & ~ALIGN_MASK;

  // free: header start wraps at 16 bits, index wraps at the heap depth
  assign free_byte = req_i.block_offset - 16'(HEADER_BYTES);
  assign free_ext  = 32'(free_byte);
  assign free_idx  = free_ext[AW+ALIGN_SHIFT-1:ALIGN_SHIFT];

  assign top_ext = 32'(heap_top_q);
  assign top_idx = top_ext[AW+ALIGN_SHIFT-1:ALIGN_SHIFT];

  assign limit = (heap_limit > 16'(HEAP_CAP)) ? 16'(HEAP_CAP) : heap_limit;

  assign blk_payload = 16'((32'(blk_q) << ALIGN_SHIFT) + 32'(HEADER_BYTES));
  assign steps_inc   = steps_q + 1'b1;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    need_d      = need_q;
    node_d      = node_q;
    steps_d     = steps_q;
    blk_d       = blk_q;
    p_d         = p_q;
    n_d         = n_q;
    fb_d        = fb_q;
    tgt_d       = tgt_q;
    heap_top_d  = heap_top_q;

    ctl         = '0;
    rd_addr     = node_q;
    size_waddr  = top_idx;
    size_wdata  = need_q[15:0];
    next_waddr  = p_q;
    next_wdata  = n_q;
    prior_waddr = n_q;
    prior_wdata = p_q;
    head_wdata  = fb_q;

    // default use of the unit: stored block size against the rounded need
    unit_a      = {1'b0, need_q};
    unit_b      = '0;
    unit_ref    = {2'b0, rd_size};

    fin         = 1'b0;
    fin_status  = STATUS_OK;
    fin_payload = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.action == ACT_FREE) begin
            fb_d    = free_idx;
            state_d = S_FREE_HEAD;
          end else begin
            need_d = need_in;
            if (head == '0) begin
              state_d = S_EXTEND;
            end else begin
              ctl.rd_en = 1'b1;
              rd_addr   = head;
              node_d    = head;
              steps_d   = '0;
              state_d   = S_WALK;
            end
          end
        end
      end

      // store data for node_q is present; one node per cycle
      S_WALK: begin
        if (unit_ge) begin
          blk_d   = node_q;
          p_d     = rd_prior;
          n_d     = rd_next;
          state_d = S_UNLINK;
        end else if ((rd_next == '0) || (steps_inc == DEPTH_W)) begin
          // end of list, or a runaway cycle: fall back to extension
          state_d = S_EXTEND;
        end else begin
          ctl.rd_en = 1'b1;
          rd_addr   = rd_next;
          node_d    = rd_next;
          steps_d   = steps_inc;
        end
      end

      S_UNLINK: begin
        if (out_free) begin
          ctl.next_we  = 1'b1;
          ctl.prior_we = 1'b1;
          fin          = 1'b1;
          fin_payload  = blk_payload;
          state_d      = S_IDLE;
        end
      end

      // unit checks top + need against the effective limit
      S_EXTEND: begin
        unit_a   = {2'b0, heap_top_q};
        unit_b   = {1'b0, need_q};
        unit_ref = {2'b0, limit};
        if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
          if (unit_ge) begin
            ctl.size_we = 1'b1;
            fin_payload = heap_top_q + 16'(HEADER_BYTES);
            heap_top_d  = unit_sum[15:0];
          end else begin
            fin_status = STATUS_OOM;
          end
        end
      end

      // push at head: block links to old head, sentinel links to block
      S_FREE_HEAD: begin
        ctl.next_we  = 1'b1;
        next_waddr   = fb_q;
        next_wdata   = head;
        ctl.prior_we = 1'b1;
        prior_waddr  = fb_q;
        prior_wdata  = '0;
        ctl.head_we  = 1'b1;
        head_wdata   = fb_q;
        // freeing the sentinel itself leaves its forward link at zero
        tgt_d        = (fb_q == '0) ? '0 : head;
        state_d      = S_FREE_LINK;
      end

      S_FREE_LINK: begin
        if (out_free) begin
          ctl.prior_we = 1'b1;
          prior_waddr  = tgt_q;
          prior_wdata  = fb_q;
          fin          = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      heap_top_q <= 16'(HEADER_BYTES);
    end else begin
      state_q    <= state_d;
      heap_top_q <= heap_top_d;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk_i) begin
    need_q  <= need_d;
    node_q  <= node_d;
    steps_q <= steps_d;
    blk_q   <= blk_d;
    p_q     <= p_d;
    n_q     <= n_d;
    fb_q    <= fb_d;
    tgt_q   <= tgt_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_status_q  <= fin_status;
      out_payload_q <= fin_payload;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.payload_offset = out_payload_q;

  // heap top only ever grows
  `FFFL_ASSERT_NEXT(a_top_grows, 1'b1, heap_top_q >= $past(heap_top_q), "heap top fell")
  // walk never passes the depth bound
  `FFFL_ASSERT_NOW(a_walk_bound, state_q == S_WALK, steps_q < DEPTH_W, "walk overran depth")
  // an out-of-memory response carries no offset
  `FFFL_ASSERT_NOW(a_oom_zero, out_valid_q && (out_status_q == STATUS_OOM),
                   out_payload_q == '0, "oom response with offset")
  // a result is only produced when the output register can take it
  `FFFL_ASSERT_NOW(a_no_overwrite, fin, out_free, "response overwritten")

endmodule
